// ===== rtl/ocsv_pkg.sv =====
// Shared types, constants and a helper function of the order feed CSV line parser.
`default_nettype none
package ocsv_pkg;

	localparam int NUM_SLOTS   = 7;
	localparam int NUM_WORDS   = 8;
	localparam int QUEUE_DEPTH = 2;

	localparam int W_ADD       = 0;
	localparam int W_CANCEL    = 1;
	localparam int W_MODIFY    = 2;
	localparam int W_TRADE     = 3;
	localparam int W_BUY       = 4;
	localparam int W_SELL      = 5;
	localparam int W_TIMESTAMP = 6;
	localparam int W_SYMBOL    = 7;

	localparam logic [7:0] CH_LF    = 8'd10;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_COMMA = 8'd44;
	localparam logic [7:0] CH_MINUS = 8'd45;
	localparam logic [7:0] CH_PLUS  = 8'd43;
	localparam logic [7:0] CH_DOT   = 8'd46;
	localparam logic [7:0] CH_ZERO  = 8'd48;
	localparam logic [7:0] CH_NINE  = 8'd57;

	localparam logic [63:0] POW10 [10] = '{
		64'd1, 64'd10, 64'd100, 64'd1000, 64'd10000, 64'd100000, 64'd1000000,
		64'd10000000, 64'd100000000, 64'd1000000000
	};

	localparam logic [3:0] WORD_LEN [NUM_WORDS] = '{
		4'd3, 4'd6, 4'd6, 4'd5, 4'd3, 4'd4, 4'd9, 4'd6
	};

	localparam logic [71:0] WORD_TEXT [NUM_WORDS] = '{
		72'("ADD"), 72'("CANCEL"), 72'("MODIFY"), 72'("TRADE"),
		72'("BUY"), 72'("SELL"), 72'("TIMESTAMP"), 72'("SYMBOL")
	};

	typedef enum logic [2:0] {
		KIND_INVALID = 3'd0,
		KIND_ADD     = 3'd1,
		KIND_CANCEL  = 3'd2,
		KIND_MODIFY  = 3'd3,
		KIND_TRADE   = 3'd4
	} kind_t;

	typedef enum logic [3:0] {
		ERR_NONE        = 4'd0,
		ERR_FEW_FIELDS  = 4'd1,
		ERR_EMPTY_TS    = 4'd2,
		ERR_BAD_TS      = 4'd3,
		ERR_NO_TYPE     = 4'd4,
		ERR_BAD_TYPE    = 4'd5,
		ERR_SHORT       = 4'd6,
		ERR_NO_ID       = 4'd7,
		ERR_BAD_ID      = 4'd8,
		ERR_BAD_SIDE    = 4'd9,
		ERR_BAD_PRICE   = 4'd10,
		ERR_BAD_QTY     = 4'd11
	} err_code_t;

	typedef struct packed {
		logic [7:0] line_byte;
		logic       end_of_stream;
		logic       restart;
	} in_word_t;

	typedef struct packed {
		logic        record_ok;
		logic [3:0]  error_code;
		logic [2:0]  event_kind;
		logic        sell_side;
		logic [63:0] stamp;
		logic [63:0] order_number;
		logic signed [63:0] price_scaled;
		logic [63:0] amount;
		logic        symbol_present;
		logic [31:0] lines_seen;
		logic [31:0] errors_seen;
	} out_word_t;

	typedef struct packed {
		logic        nonempty;
		logic        digits;
		logic        first_digit;
		logic        zero_only;
		logic [63:0] num;
		logic [63:0] pmag;
		logic        pneg;
		logic [NUM_WORDS-1:0] match;
	} slot_t;

	typedef struct packed {
		logic                        restart;
		logic                        close;
		logic                        has_content;
		logic [4:0]                  nf;
		slot_t [NUM_SLOTS-1:0]       slots;
	} line_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

	function automatic logic word_hit(input logic [2:0] w, input logic [3:0] p,
			input logic [7:0] up);
		logic [3:0]  l;
		logic [71:0] t;
		int          sh;
		l = WORD_LEN[w];
		t = WORD_TEXT[w];
		sh = 8 * (int'(l) - 1 - int'(p));
		if (p >= l) begin
			return 1'b0;
		end
		return t[sh +: 8] == up;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/ocsv_front.sv =====
// Front part: classifies feed bytes, decodes fields and hands finished lines to the queue.
`default_nettype none
module ocsv_front #(
	parameter int FRACTION_DIGITS = 8
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               accept,
	input  wire ocsv_pkg::in_word_t word,
	output logic                    push,
	output ocsv_pkg::line_entry_t   entry
);

	typedef struct packed {
		logic [3:0]  len;
		logic        all_digits;
		logic        first_digit;
		logic        zero_only;
		logic [63:0] num;
		logic [ocsv_pkg::NUM_WORDS-1:0] words;
		logic        neg;
		logic        dot;
		logic        bad;
		logic        body;
		logic [3:0]  fdig;
		logic [63:0] pacc;
	} field_acc_t;

	function automatic field_acc_t field_clear();
		field_acc_t r;
		r = '0;
		r.all_digits = 1'b1;
		r.words = '1;
		return r;
	endfunction

	function automatic field_acc_t feed_space(input field_acc_t s);
		field_acc_t r;
		r = s;
		if (s.len == 4'd0) begin
			r.first_digit = 1'b0;
		end
		r.zero_only = 1'b0;
		r.all_digits = 1'b0;
		r.words = '0;
		r.body = 1'b1;
		r.bad = 1'b1;
		if (s.len != 4'd15) begin
			r.len = s.len + 4'd1;
		end
		return r;
	endfunction

	function automatic field_acc_t feed_char(input field_acc_t s, input logic [7:0] c);
		field_acc_t  r;
		logic        dig;
		logic [3:0]  d;
		logic [7:0]  up;
		logic [63:0] weight;
		logic [63:0] term;
		r = s;
		dig = (c >= ocsv_pkg::CH_ZERO) && (c <= ocsv_pkg::CH_NINE);
		d = c[3:0];
		up = (c >= 8'd97 && c <= 8'd122) ? c - 8'd32 : c;
		weight = s.dot ? ocsv_pkg::POW10[4'(FRACTION_DIGITS - 1) - s.fdig]
			: ocsv_pkg::POW10[FRACTION_DIGITS];
		term = weight * {60'd0, d};
		if (s.len == 4'd0) begin
			r.first_digit = dig;
			r.zero_only = (c == ocsv_pkg::CH_ZERO);
		end else begin
			r.zero_only = 1'b0;
		end
		if (dig) begin
			r.num = (s.num << 3) + (s.num << 1) + {60'd0, d};
		end else begin
			r.all_digits = 1'b0;
		end
		for (int w = 0; w < ocsv_pkg::NUM_WORDS; w++) begin
			if (!ocsv_pkg::word_hit(3'(w), s.len, up)) begin
				r.words[w] = 1'b0;
			end
		end
		if (s.len == 4'd0 && (c == ocsv_pkg::CH_MINUS || c == ocsv_pkg::CH_PLUS)) begin
			r.neg = (c == ocsv_pkg::CH_MINUS);
		end else begin
			r.body = 1'b1;
			if (!s.dot && c == ocsv_pkg::CH_DOT) begin
				r.dot = 1'b1;
			end else if (!dig) begin
				r.bad = 1'b1;
			end else if (!s.dot) begin
				r.pacc = (s.pacc << 3) + (s.pacc << 1) + term;
			end else if (s.fdig < 4'(FRACTION_DIGITS)) begin
				r.pacc = s.pacc + term;
				r.fdig = s.fdig + 4'd1;
			end
		end
		if (s.len != 4'd15) begin
			r.len = s.len + 4'd1;
		end
		return r;
	endfunction

	function automatic ocsv_pkg::slot_t commit(input field_acc_t s);
		ocsv_pkg::slot_t r;
		r.nonempty = (s.len != 4'd0);
		r.digits = r.nonempty && s.all_digits;
		r.first_digit = s.first_digit;
		r.zero_only = s.zero_only;
		r.num = s.num;
		for (int w = 0; w < ocsv_pkg::NUM_WORDS; w++) begin
			r.match[w] = s.words[w] && (s.len == ocsv_pkg::WORD_LEN[w]);
		end
		r.pmag = (r.nonempty && s.body && !s.bad) ? s.pacc : 64'd0;
		r.pneg = s.neg;
		return r;
	endfunction

	field_acc_t                                cur_q;
	ocsv_pkg::slot_t [ocsv_pkg::NUM_SLOTS-1:0] slots_q;
	logic [3:0]                                fp_q;
	logic                                      pend_q;
	logic                                      hc_q;

	field_acc_t                                cur_b, st1, st2, cur_after, commit_src, cur_next;
	ocsv_pkg::slot_t [ocsv_pkg::NUM_SLOTS-1:0] slots_b, slots_after;
	logic [3:0]                                fp_b, fp_after;
	logic                                      pend_b, hc_b, hc_after, pend_after;
	logic                                      is_nl, is_trim, is_comma, close;

	always_comb begin
		if (word.restart) begin
			cur_b = field_clear();
			slots_b = '0;
			fp_b = 4'd0;
			pend_b = 1'b0;
			hc_b = 1'b0;
		end else begin
			cur_b = cur_q;
			slots_b = slots_q;
			fp_b = fp_q;
			pend_b = pend_q;
			hc_b = hc_q;
		end
		is_nl = (word.line_byte == ocsv_pkg::CH_LF);
		is_trim = (word.line_byte == ocsv_pkg::CH_CR) || (word.line_byte == ocsv_pkg::CH_SPACE);
		is_comma = (word.line_byte == ocsv_pkg::CH_COMMA);
		close = is_nl || word.end_of_stream;
		st1 = (pend_b && !is_trim && !is_nl) ? feed_space(cur_b) : cur_b;
		st2 = feed_char(st1, word.line_byte);
		if (is_nl || is_trim) begin
			cur_after = cur_b;
		end else if (is_comma) begin
			cur_after = st1;
		end else begin
			cur_after = st2;
		end
		commit_src = cur_after;
		slots_after = slots_b;
		if ((is_comma || close) && fp_b < 4'(ocsv_pkg::NUM_SLOTS)) begin
			slots_after[fp_b[2:0]] = commit(commit_src);
		end
		fp_after = (is_comma && !is_nl && fp_b != 4'd15) ? fp_b + 4'd1 : fp_b;
		cur_next = is_comma ? field_clear() : cur_after;
		hc_after = hc_b || (!is_nl && !is_trim);
		pend_after = is_trim;
		push = accept && (close || word.restart);
		entry.restart = word.restart;
		entry.close = close;
		entry.has_content = hc_after;
		entry.nf = {1'b0, fp_after} + 5'd1;
		entry.slots = slots_after;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= field_clear();
			slots_q <= '0;
			fp_q <= 4'd0;
			pend_q <= 1'b0;
			hc_q <= 1'b0;
		end else if (accept) begin
			if (close) begin
				cur_q <= field_clear();
				slots_q <= '0;
				fp_q <= 4'd0;
				pend_q <= 1'b0;
				hc_q <= 1'b0;
			end else begin
				cur_q <= cur_next;
				slots_q <= slots_after;
				fp_q <= fp_after;
				pend_q <= pend_after;
				hc_q <= hc_after;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/ocsv_queue.sv =====
// Short queue of finished lines between the front and back parts.
`default_nettype none
module ocsv_queue (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	input  wire ocsv_pkg::line_entry_t wr_entry,
	input  wire logic                  pop,
	output ocsv_pkg::line_entry_t      rd_entry,
	output ocsv_pkg::queue_status_t    status
);

	localparam int PTR_W = $clog2(ocsv_pkg::QUEUE_DEPTH);

	ocsv_pkg::line_entry_t mem_q [ocsv_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0]      wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0]        count_q;

	always_comb begin
		status.full = (count_q == (PTR_W + 1)'(ocsv_pkg::QUEUE_DEPTH));
		status.empty = (count_q == '0);
		rd_entry = mem_q[rd_ptr_q];
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(ocsv_pkg::QUEUE_DEPTH - 1)) ? '0
					: wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(ocsv_pkg::QUEUE_DEPTH - 1)) ? '0
					: rd_ptr_q + PTR_W'(1);
			end
			unique case ({push, pop})
				2'b10: count_q <= count_q + (PTR_W + 1)'(1);
				2'b01: count_q <= count_q - (PTR_W + 1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && status.full && !pop))
		else $error("Line queue written while full.");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && status.empty))
		else $error("Line queue read while empty.");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (PTR_W + 1)'(ocsv_pkg::QUEUE_DEPTH))
		else $error("Line queue count out of range.");

endmodule
`default_nettype wire

// ===== rtl/ocsv_back.sv =====
// Back part: decodes one queued line into a record and keeps the line and error counts.
`default_nettype none
module ocsv_back #(
	parameter int COUNTER_WIDTH = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  head_valid,
	input  wire ocsv_pkg::line_entry_t head,
	output logic                       pop,
	output logic                       record_valid,
	input  wire logic                  record_stall,
	output ocsv_pkg::out_word_t        record_word
);

	logic                     flag_q;
	logic [COUNTER_WIDTH-1:0] lc_q, ec_q;
	logic                     out_valid_q;
	ocsv_pkg::out_word_t      out_q;

	logic                     flag_b, flag_n, advance, produce, o_set, use_sym;
	logic [COUNTER_WIDTH-1:0] lc_b, ec_b, lc_n, ec_n;
	logic [4:0]               ob;
	ocsv_pkg::slot_t          s0, ts, et, id, sd, px, qt;
	ocsv_pkg::kind_t          kind;
	ocsv_pkg::err_code_t      err;
	logic [63:0]              qty, price, lc_w, ec_w;
	ocsv_pkg::out_word_t      res;

	always_comb begin
		advance = !out_valid_q || !record_stall;
		pop = head_valid && advance;
		flag_b = head.restart ? 1'b0 : flag_q;
		lc_b = head.restart ? '0 : lc_q;
		ec_b = head.restart ? '0 : ec_q;
		s0 = head.slots[0];
		o_set = (head.nf >= 5'd7) && s0.nonempty && !s0.first_digit;
		use_sym = flag_b || o_set;
		ob = {4'd0, use_sym};
		ts = head.slots[3'(ob)];
		et = head.slots[3'(ob + 5'd1)];
		id = head.slots[3'(ob + 5'd2)];
		sd = head.slots[3'(ob + 5'd3)];
		px = head.slots[3'(ob + 5'd4)];
		qt = head.slots[3'(ob + 5'd5)];
		priority if (et.match[ocsv_pkg::W_ADD]) kind = ocsv_pkg::KIND_ADD;
		else if (et.match[ocsv_pkg::W_CANCEL]) kind = ocsv_pkg::KIND_CANCEL;
		else if (et.match[ocsv_pkg::W_MODIFY]) kind = ocsv_pkg::KIND_MODIFY;
		else if (et.match[ocsv_pkg::W_TRADE]) kind = ocsv_pkg::KIND_TRADE;
		else kind = ocsv_pkg::KIND_INVALID;
		qty = qt.digits ? qt.num : 64'd0;
		price = px.pneg ? 64'd0 - px.pmag : px.pmag;
		priority if (head.nf < 5'd2) err = ocsv_pkg::ERR_FEW_FIELDS;
		else if (!ts.nonempty) err = ocsv_pkg::ERR_EMPTY_TS;
		else if (!ts.digits) err = ocsv_pkg::ERR_BAD_TS;
		else if (ob + 5'd1 >= head.nf) err = ocsv_pkg::ERR_NO_TYPE;
		else if (kind == ocsv_pkg::KIND_INVALID) err = ocsv_pkg::ERR_BAD_TYPE;
		else if (kind == ocsv_pkg::KIND_CANCEL && head.nf < ob + 5'd3)
			err = ocsv_pkg::ERR_SHORT;
		else if (kind == ocsv_pkg::KIND_CANCEL && !id.nonempty) err = ocsv_pkg::ERR_NO_ID;
		else if (kind == ocsv_pkg::KIND_CANCEL && !id.digits) err = ocsv_pkg::ERR_BAD_ID;
		else if (kind == ocsv_pkg::KIND_CANCEL) err = ocsv_pkg::ERR_NONE;
		else if (head.nf < ob + 5'd6) err = ocsv_pkg::ERR_SHORT;
		else if (kind == ocsv_pkg::KIND_TRADE) err = ocsv_pkg::ERR_NONE;
		else if (!id.nonempty) err = ocsv_pkg::ERR_NO_ID;
		else if (!id.digits) err = ocsv_pkg::ERR_BAD_ID;
		else if (!(sd.match[ocsv_pkg::W_SELL] || sd.match[ocsv_pkg::W_BUY]))
			err = ocsv_pkg::ERR_BAD_SIDE;
		else if (px.pmag == 64'd0 && px.nonempty && !px.zero_only)
			err = ocsv_pkg::ERR_BAD_PRICE;
		else if (qty == 64'd0) err = ocsv_pkg::ERR_BAD_QTY;
		else err = ocsv_pkg::ERR_NONE;
		produce = head.close && head.has_content
			&& !(s0.match[ocsv_pkg::W_TIMESTAMP] || s0.match[ocsv_pkg::W_SYMBOL]);
		flag_n = flag_b;
		lc_n = lc_b;
		ec_n = ec_b;
		if (head.close) begin
			lc_n = lc_b + COUNTER_WIDTH'(1);
		end
		if (produce) begin
			if (head.nf >= 5'd2) begin
				flag_n = use_sym;
			end
			if (err != ocsv_pkg::ERR_NONE) begin
				ec_n = ec_b + COUNTER_WIDTH'(1);
			end
		end
		lc_w = 64'(lc_n);
		ec_w = 64'(ec_n);
		res = '0;
		res.error_code = err;
		res.symbol_present = (err == ocsv_pkg::ERR_FEW_FIELDS) ? 1'b0 : use_sym;
		res.lines_seen = lc_w[31:0];
		res.errors_seen = ec_w[31:0];
		if (err == ocsv_pkg::ERR_NONE) begin
			res.record_ok = 1'b1;
			res.event_kind = kind;
			res.stamp = ts.num;
			res.order_number = (kind == ocsv_pkg::KIND_TRADE) ? 64'd0 : id.num;
			if (kind != ocsv_pkg::KIND_CANCEL) begin
				res.sell_side = sd.match[ocsv_pkg::W_SELL];
				res.price_scaled = price;
				res.amount = qty;
			end
		end
		record_valid = out_valid_q;
		record_word = out_q;
	end

	always_ff @(posedge clk) begin
		if (pop && produce) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q <= 1'b0;
			lc_q <= '0;
			ec_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				flag_q <= flag_n;
				lc_q <= lc_n;
				ec_q <= ec_n;
			end
			if (advance) begin
				out_valid_q <= pop && produce;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/order_feed_csv_line_parser.sv =====
// Top level of the order feed CSV line parser.
// Takes one feed byte per cycle on the feed channel and gives one record word per data line
// on the record channel. The front part decodes the byte that ends a line and writes it into
// the line queue; the back part decodes the queued line into its output register. The
// two-entry line queue sets the input stall, which rises only while two finished lines wait
// for the back part, so the feed runs at one byte per cycle as long as records are taken.
// Header and empty lines are counted but give no record.
`default_nettype none
module order_feed_csv_line_parser #(
	parameter int FRACTION_DIGITS = 8,
	parameter int COUNTER_WIDTH = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               feed_valid,
	output logic                    feed_stall,
	input  wire ocsv_pkg::in_word_t feed_word,
	output logic                    record_valid,
	input  wire logic               record_stall,
	output ocsv_pkg::out_word_t     record_word
);

	ocsv_pkg::line_entry_t   wr_entry, rd_entry;
	ocsv_pkg::queue_status_t status;
	logic                    accept, push, pop;

	assign feed_stall = status.full;
	assign accept = feed_valid && !status.full;

	ocsv_front #(
		.FRACTION_DIGITS(FRACTION_DIGITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.word(feed_word),
		.push(push),
		.entry(wr_entry)
	);

	ocsv_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wr_entry(wr_entry),
		.pop(pop),
		.rd_entry(rd_entry),
		.status(status)
	);

	ocsv_back #(
		.COUNTER_WIDTH(COUNTER_WIDTH)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head_valid(!status.empty),
		.head(rd_entry),
		.pop(pop),
		.record_valid(record_valid),
		.record_stall(record_stall),
		.record_word(record_word)
	);

endmodule
`default_nettype wire
